### rtl/ttcb_pkg.sv
// Shared types, codes and constants for the text terminal character buffer.
`default_nettype none

package ttcb_pkg;

   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int CHAR_W     = 8;
   localparam int ARG_W      = 8;
   localparam int FUNC_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam int DEF_MAX_COLS = 80;
   localparam int DEF_MAX_ROWS = 25;
   localparam int DEF_TAB_STEP = 8;

   localparam int COLS_RESET  = 80;
   localparam int LINES_RESET = 25;

   localparam logic [CHAR_W-1:0] BLANK    = 8'h20;
   localparam logic [CHAR_W-1:0] NO_CHAR  = 8'hFF;
   localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GOTO  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES = 1'b1;

   typedef struct packed {
      logic [CHAR_W-1:0] char_read;
      logic              read_in_range;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [CHAR_W-1:0] last_char;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/ttcb_mem.sv
// Screen store: one write port, one read port with registered read data.
`default_nettype none

module ttcb_mem #(
   parameter int DEPTH = ttcb_pkg::DEF_MAX_COLS * ttcb_pkg::DEF_MAX_ROWS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [ADDR_W-1:0]             waddr,
   input  wire logic [ttcb_pkg::CHAR_W-1:0]   wdata,
   input  wire logic                          re,
   input  wire logic [ADDR_W-1:0]             raddr,
   output logic      [ttcb_pkg::CHAR_W-1:0]   rdata
);

   logic [ttcb_pkg::CHAR_W-1:0] store [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= store[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/ttcb_ctrl.sv
// Command sequencer: cursor, init/clear/scroll sweeps and store access.
`default_nettype none

module ttcb_ctrl #(
   parameter int MAX_COLS = ttcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ttcb_pkg::DEF_MAX_ROWS,
   parameter int TAB_STEP = ttcb_pkg::DEF_TAB_STEP,
   localparam int DEPTH  = MAX_COLS * MAX_ROWS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ttcb_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [ttcb_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [ttcb_pkg::ARG_W-1:0]    req_col_arg,
   input  wire logic [ttcb_pkg::ARG_W-1:0]    req_row_arg,
   input  wire logic [ttcb_pkg::COL_W-1:0]    cols,
   input  wire logic [ttcb_pkg::ROW_W-1:0]    lines,
   output logic                               done,
   output ttcb_pkg::rsp_type                  res,
   input  wire logic                          rsp_free,
   output logic                               mem_we,
   output logic      [ADDR_W-1:0]             mem_waddr,
   output logic      [ttcb_pkg::CHAR_W-1:0]   mem_wdata,
   output logic                               mem_re,
   output logic      [ADDR_W-1:0]             mem_raddr,
   input  wire logic [ttcb_pkg::CHAR_W-1:0]   mem_rdata
);

   localparam int COL_W  = ttcb_pkg::COL_W;
   localparam int ROW_W  = ttcb_pkg::ROW_W;
   localparam int ARG_W  = ttcb_pkg::ARG_W;
   localparam int CHAR_W = ttcb_pkg::CHAR_W;

   localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(MAX_COLS);
   localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_COPY  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_BLANK = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                     state_ff, state_in;
   logic [ttcb_pkg::FUNC_W-1:0]    func_ff, func_in;
   logic [CHAR_W-1:0]              ch_ff, ch_in;
   logic [ARG_W-1:0]               cola_ff, cola_in;
   logic [ARG_W-1:0]               rowa_ff, rowa_in;
   logic [COL_W-1:0]               col_ff, col_in;
   logic [ROW_W-1:0]               row_ff, row_in;
   logic [CHAR_W-1:0]              last_ff, last_in;
   logic [ADDR_W-1:0]              base_ff, base_in;
   logic [COL_W-1:0]               c_ff, c_in;
   logic [ROW_W-1:0]               r_ff, r_in;
   logic                           pend_ff, pend_in;
   logic [ADDR_W-1:0]              pend_addr_ff, pend_addr_in;

   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;
   logic              in_window;
   logic              accepted;
   logic              is_read;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] arg_addr;
   logic [ADDR_W-1:0] sweep_addr;
   logic [COL_W:0]    col_inc;
   logic [COL_W:0]    tab_sum;
   logic              keep_char;
   logic              at_bottom;

   assign last_col  = cols - COL_W'(1);
   assign last_row  = lines - ROW_W'(1);
   assign in_window = (cola_ff < ARG_W'(cols)) && (rowa_ff < ARG_W'(lines));
   assign accepted  = req_valid && !req_stall;
   assign is_read   = (func_ff == ttcb_pkg::FUNC_READ);
   assign cur_addr  = ADDR_W'(row_ff) * COLS_A + ADDR_W'(col_ff);
   assign arg_addr  = ADDR_W'(rowa_ff[ROW_W-1:0]) * COLS_A + ADDR_W'(cola_ff[COL_W-1:0]);
   assign sweep_addr = base_ff + ADDR_W'(c_ff);
   assign col_inc   = {1'b0, col_ff} + (COL_W+1)'(1);
   assign tab_sum   = {1'b0, col_ff} + (COL_W+1)'(TAB_STEP);
   assign at_bottom = (row_ff >= last_row);
   assign keep_char = ((ch_ff >= ttcb_pkg::CH_PRINT_LO) && (ch_ff <= ttcb_pkg::CH_PRINT_HI))
                   || ((ch_ff >= ttcb_pkg::CH_BELL) && (ch_ff <= ttcb_pkg::CH_CR));

   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE);

   always_comb begin
      res.char_read     = is_read ? (in_window ? mem_rdata : ttcb_pkg::NO_CHAR) : '0;
      res.read_in_range = is_read && in_window;
      res.cursor_col    = col_ff;
      res.cursor_row    = row_ff;
      res.last_char     = last_ff;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      ch_in        = ch_ff;
      cola_in      = cola_ff;
      rowa_in      = rowa_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_addr;
      mem_wdata    = ttcb_pkg::BLANK;
      mem_re       = 1'b0;
      mem_raddr    = sweep_addr;

      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff;
            if (base_ff == LAST_A) begin
               base_in  = '0;
               state_in = S_IDLE;
            end else begin
               base_in = base_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (col_ff > last_col) col_in = last_col;
            if (row_ff > last_row) row_in = last_row;
            if (accepted) begin
               func_in  = req_func;
               ch_in    = req_char_code;
               cola_in  = req_col_arg;
               rowa_in  = req_row_arg;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            c_in     = '0;
            unique case (func_ff)
               ttcb_pkg::FUNC_PUT: begin
                  if (keep_char) begin
                     last_in = ch_ff;
                     unique case (ch_ff)
                        ttcb_pkg::CH_CR:   col_in = '0;
                        ttcb_pkg::CH_TAB: begin
                           col_in = (tab_sum >= {1'b0, cols}) ? last_col : tab_sum[COL_W-1:0];
                        end
                        ttcb_pkg::CH_BS: begin
                           if (col_ff != '0) col_in = col_ff - COL_W'(1);
                        end
                        ttcb_pkg::CH_BELL: ;
                        default: begin
                           if (ch_ff != ttcb_pkg::CH_LF) begin
                              mem_we    = 1'b1;
                              mem_waddr = cur_addr;
                              mem_wdata = ch_ff;
                              col_in    = col_inc[COL_W-1:0];
                           end
                           if (ch_ff == ttcb_pkg::CH_LF || col_inc >= {1'b0, cols}) begin
                              if (ch_ff != ttcb_pkg::CH_LF) col_in = '0;
                              if (!at_bottom) begin
                                 row_in = row_ff + ROW_W'(1);
                              end else if (last_row != '0) begin
                                 base_in  = COLS_A;
                                 r_in     = ROW_W'(1);
                                 state_in = S_COPY;
                              end else begin
                                 base_in  = '0;
                                 state_in = S_BLANK;
                              end
                           end
                        end
                     endcase
                  end
               end
               ttcb_pkg::FUNC_GOTO: begin
                  if (in_window) begin
                     col_in = cola_ff[COL_W-1:0];
                     row_in = rowa_ff[ROW_W-1:0];
                  end
               end
               ttcb_pkg::FUNC_READ: begin
                  mem_re    = in_window;
                  mem_raddr = arg_addr;
               end
               ttcb_pkg::FUNC_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  base_in  = '0;
                  r_in     = '0;
                  state_in = S_CLEAR;
               end
            endcase
         end
         S_COPY: begin
            mem_we       = pend_ff;
            mem_waddr    = pend_addr_ff;
            mem_wdata    = mem_rdata;
            mem_re       = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = sweep_addr - COLS_A;
            if (c_ff == last_col) begin
               c_in = '0;
               if (r_ff == last_row) begin
                  state_in = S_DRAIN;
               end else begin
                  r_in    = r_ff + ROW_W'(1);
                  base_in = base_ff + COLS_A;
               end
            end else begin
               c_in = c_ff + COL_W'(1);
            end
         end
         S_DRAIN: begin
            mem_we    = pend_ff;
            mem_waddr = pend_addr_ff;
            mem_wdata = mem_rdata;
            c_in      = '0;
            state_in  = S_BLANK;
         end
         S_BLANK: begin
            mem_we = 1'b1;
            if (c_ff == last_col) begin
               state_in = S_DONE;
            end else begin
               c_in = c_ff + COL_W'(1);
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            if (c_ff == last_col) begin
               c_in = '0;
               if (r_ff == last_row) begin
                  state_in = S_DONE;
               end else begin
                  r_in    = r_ff + ROW_W'(1);
                  base_in = base_ff + COLS_A;
               end
            end else begin
               c_in = c_ff + COL_W'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         col_ff   <= '0;
         row_ff   <= '0;
         last_ff  <= '0;
         base_ff  <= '0;
         c_ff     <= '0;
         r_ff     <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         last_ff  <= last_in;
         base_ff  <= base_in;
         c_ff     <= c_in;
         r_ff     <= r_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      ch_ff        <= ch_in;
      cola_ff      <= cola_in;
      rowa_ff      <= rowa_in;
      pend_addr_ff <= pend_addr_in;
   end

   a_pend_in_copy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_COPY || state_ff == S_DRAIN))
      else $error("pending copy write outside scroll copy");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accepted |=> (state_ff == S_EXEC))
      else $error("accepted beat did not enter execute");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != S_IDLE && state_ff != S_DONE))
      else $error("store write while idle or done");

   a_base_range: assert property (@(posedge clock) disable iff (reset)
      base_ff <= LAST_A)
      else $error("sweep base past end of store");

endmodule

`default_nettype wire

### rtl/text_terminal_char_buffer_top.sv
// Top level of the text terminal character buffer: config, result register, store.
//
//   port group | direction | beat contents
//   req_*      | in        | func, char_code, col_arg, row_arg
//   rsp_*      | out       | char_read, read_in_range, cursor_col, cursor_row, last_char
//   csr_*      | in        | register index and write data, no read-back
//
// Go to, read and most put chars pass from idle through execute and done into the result register;
// no new beat is taken until the controller is back in idle. A put char that scrolls adds a copy
// sweep and a drain, then blanks the bottom row (only the blank when lines is 1); clear writes
// spaces to lines*cols entries, one store write per cycle. After reset a fill pass writes spaces
// to all MAX_ROWS*MAX_COLS entries, one per cycle, with req_stall high.
// A new beat is taken while a result waits; its own result holds req_stall until rsp frees.
`default_nettype none

module text_terminal_char_buffer_top #(
   parameter int MAX_COLS = ttcb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ttcb_pkg::DEF_MAX_ROWS,
   parameter int TAB_STEP = ttcb_pkg::DEF_TAB_STEP
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ttcb_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [ttcb_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [ttcb_pkg::ARG_W-1:0]        req_col_arg,
   input  wire logic [ttcb_pkg::ARG_W-1:0]        req_row_arg,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [ttcb_pkg::CHAR_W-1:0]       rsp_char_read,
   output logic                                   rsp_read_in_range,
   output logic      [ttcb_pkg::COL_W-1:0]        rsp_cursor_col,
   output logic      [ttcb_pkg::ROW_W-1:0]        rsp_cursor_row,
   output logic      [ttcb_pkg::CHAR_W-1:0]       rsp_last_char,
   input  wire logic                              csr_we,
   input  wire logic [ttcb_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire logic [ttcb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W  = ttcb_pkg::COL_W;
   localparam int ROW_W  = ttcb_pkg::ROW_W;
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [COL_W-1:0] COLS_RST =
      COL_W'((ttcb_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : ttcb_pkg::COLS_RESET);
   localparam logic [ROW_W-1:0] LINES_RST =
      ROW_W'((ttcb_pkg::LINES_RESET > MAX_ROWS) ? MAX_ROWS : ttcb_pkg::LINES_RESET);

   logic [COL_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]  lines_ff, lines_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ttcb_pkg::rsp_type rsp_ff, rsp_in;

   logic [COL_W-1:0]  wcols;
   logic [ROW_W-1:0]  wlines;
   logic              done;
   logic              rsp_free;
   ttcb_pkg::rsp_type res;

   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [ttcb_pkg::CHAR_W-1:0] mem_wdata;
   logic                        mem_re;
   logic [ADDR_W-1:0]           mem_raddr;
   logic [ttcb_pkg::CHAR_W-1:0] mem_rdata;

   assign wcols  = csr_wdata[COL_W-1:0];
   assign wlines = csr_wdata[ROW_W-1:0];

   always_comb begin
      cols_in  = cols_ff;
      lines_in = lines_ff;
      if (csr_we) begin
         unique case (csr_idx)
            ttcb_pkg::CSR_COLS: begin
               if (wcols == '0)                 cols_in = COL_W'(1);
               else if (int'(wcols) > MAX_COLS) cols_in = COL_W'(MAX_COLS);
               else                             cols_in = wcols;
            end
            ttcb_pkg::CSR_LINES: begin
               if (wlines == '0)                 lines_in = ROW_W'(1);
               else if (int'(wlines) > MAX_ROWS) lines_in = ROW_W'(MAX_ROWS);
               else                              lines_in = wlines;
            end
         endcase
      end
   end

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_in       = (done && rsp_free) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= COLS_RST;
         lines_ff     <= LINES_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         cols_ff      <= cols_in;
         lines_ff     <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_read     = rsp_ff.char_read;
   assign rsp_read_in_range = rsp_ff.read_in_range;
   assign rsp_cursor_col    = rsp_ff.cursor_col;
   assign rsp_cursor_row    = rsp_ff.cursor_row;
   assign rsp_last_char     = rsp_ff.last_char;

   ttcb_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .TAB_STEP (TAB_STEP)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_col_arg   (req_col_arg),
      .req_row_arg   (req_row_arg),
      .cols          (cols_ff),
      .lines         (lines_ff),
      .done          (done),
      .res           (res),
      .rsp_free      (rsp_free),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_re        (mem_re),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   ttcb_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

### bench/text_terminal_char_buffer_checker.sv
// Checker for the text terminal character buffer: screen predictor and result comparison.
`default_nettype none

module text_terminal_char_buffer_checker
   import ttcb_pkg::*;
#(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int TAB_STEP = DEF_TAB_STEP
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   input  wire logic [ARG_W-1:0]      req_col_arg,
   input  wire logic [ARG_W-1:0]      req_row_arg,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [CHAR_W-1:0]     rsp_char_read,
   input  wire logic                  rsp_read_in_range,
   input  wire logic [COL_W-1:0]      rsp_cursor_col,
   input  wire logic [ROW_W-1:0]      rsp_cursor_row,
   input  wire logic [CHAR_W-1:0]     rsp_last_char,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_idx,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding
);

   logic [CHAR_W-1:0] screen_img [MAX_ROWS][MAX_COLS];
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [CHAR_W-1:0] last_code;
   int unsigned       act_cols;
   int unsigned       act_lines;
   rsp_type           screen_status_q [$];

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   task automatic fit_cursor();
      if (cur_col >= act_cols) cur_col = COL_W'(act_cols - 1);
      if (cur_row >= act_lines) cur_row = ROW_W'(act_lines - 1);
   endtask

   task automatic blank_window();
      for (int r = 0; r < act_lines; r++)
         for (int c = 0; c < act_cols; c++)
            screen_img[r][c] = BLANK;
   endtask

   task automatic advance_line();
      if (cur_row + 1 >= act_lines) begin
         for (int r = 0; r + 1 < act_lines; r++)
            for (int c = 0; c < act_cols; c++)
               screen_img[r][c] = screen_img[r+1][c];
         for (int c = 0; c < act_cols; c++)
            screen_img[act_lines-1][c] = BLANK;
         cur_row = ROW_W'(act_lines - 1);
      end else begin
         cur_row = ROW_W'(cur_row + 1);
      end
   endtask

   task automatic put_byte(input logic [CHAR_W-1:0] ch);
      int nxt;
      if (!((ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) || (ch >= CH_BELL && ch <= CH_CR)))
         return;
      last_code = ch;
      case (ch)
         CH_LF: advance_line();
         CH_CR: cur_col = '0;
         CH_TAB: begin
            nxt = int'(cur_col) + TAB_STEP;
            if (nxt >= act_cols) nxt = act_cols - 1;
            cur_col = COL_W'(nxt);
         end
         CH_BS: begin
            if (cur_col > 0) cur_col = COL_W'(cur_col - 1);
         end
         CH_BELL: ;
         default: begin
            screen_img[cur_row][cur_col] = ch;
            if (cur_col + 1 >= act_cols) begin
               cur_col = '0;
               advance_line();
            end else begin
               cur_col = COL_W'(cur_col + 1);
            end
         end
      endcase
   endtask

   task automatic predict_terminal(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                                   input logic [ARG_W-1:0] c, input logic [ARG_W-1:0] r,
                                   output rsp_type res);
      bit in_window;
      in_window = (c < act_cols) && (r < act_lines);
      res = '0;
      case (f)
         FUNC_PUT: put_byte(ch);
         FUNC_GOTO: begin
            if (in_window) begin
               cur_col = c[COL_W-1:0];
               cur_row = r[ROW_W-1:0];
            end
         end
         FUNC_READ: begin
            if (in_window) begin
               res.char_read = screen_img[r][c];
               res.read_in_range = 1'b1;
            end else begin
               res.char_read = NO_CHAR;
            end
         end
         default: begin
            blank_window();
            cur_col = '0;
            cur_row = '0;
         end
      endcase
      res.cursor_col = cur_col;
      res.cursor_row = cur_row;
      res.last_char = last_code;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         if (mismatch_count < 10)
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < MAX_COLS; c++)
               screen_img[r][c] = BLANK;
         cur_col = '0;
         cur_row = '0;
         last_code = '0;
         act_cols = clamp_size(COLS_RESET, MAX_COLS);
         act_lines = clamp_size(LINES_RESET, MAX_ROWS);
         screen_status_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_COLS)
               act_cols = clamp_size(int'(csr_wdata), MAX_COLS);
            else
               act_lines = clamp_size(int'(csr_wdata[ROW_W-1:0]), MAX_ROWS);
            fit_cursor();
         end
         if (rsp_valid && !rsp_stall) begin
            if (screen_status_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result beat with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = screen_status_q.pop_front();
               check_field("char_read", int'(want.char_read), int'(rsp_char_read));
               check_field("read_in_range", int'(want.read_in_range),
                           int'(rsp_read_in_range));
               check_field("cursor_col", int'(want.cursor_col), int'(rsp_cursor_col));
               check_field("cursor_row", int'(want.cursor_row), int'(rsp_cursor_row));
               check_field("last_char", int'(want.last_char), int'(rsp_last_char));
            end
         end
         if (req_valid && !req_stall) begin
            predict_terminal(req_func, req_char_code, req_col_arg, req_row_arg, want);
            screen_status_q.push_back(want);
         end
      end
      outstanding = screen_status_q.size();
   end

endmodule

`default_nettype wire

### bench/tb_text_terminal_char_buffer_top.sv
// Testbench top for the text terminal character buffer: stimulus, idling, watchdog, verdict.
`default_nettype none

module tb_text_terminal_char_buffer_top;
   import ttcb_pkg::*;

   localparam int QUIET_LIMIT  = 25000;
   localparam int N_PHASES     = 12;
   localparam int PHASE_ITEMS  = 102;
   localparam int PHASE_COLS  [N_PHASES] = '{0, 127, 8, 1, 80, 13, 100, 3, 37, 5, 16, 79};
   localparam int PHASE_LINES [N_PHASES] = '{0, 31, 4, 25, 1, 6, 24, 2, 10, 3, 7, 12};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = FUNC_PUT;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [ARG_W-1:0]      req_col_arg = '0;
   logic [ARG_W-1:0]      req_row_arg = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_W-1:0]     rsp_char_read;
   logic                  rsp_read_in_range;
   logic [COL_W-1:0]      rsp_cursor_col;
   logic [ROW_W-1:0]      rsp_cursor_row;
   logic [CHAR_W-1:0]     rsp_last_char;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx = CSR_COLS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending_rsp;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_terminal_char_buffer_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_char_code(req_char_code), .req_col_arg(req_col_arg), .req_row_arg(req_row_arg),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_char_read(rsp_char_read),
      .rsp_read_in_range(rsp_read_in_range), .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row), .rsp_last_char(rsp_last_char),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   text_terminal_char_buffer_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_char_code(req_char_code), .req_col_arg(req_col_arg), .req_row_arg(req_row_arg),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_char_read(rsp_char_read),
      .rsp_read_in_range(rsp_read_in_range), .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row), .rsp_last_char(rsp_last_char),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .outstanding(pending_rsp)
   );

   // random result-side stall bursts
   always @(negedge clock) begin
      if (!idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[text_terminal_char_buffer_top] ERROR");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                           input logic [ARG_W-1:0] c, input logic [ARG_W-1:0] r);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_char_code <= ch;
      req_col_arg <= c;
      req_row_arg <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_screen_size(input logic [CSR_DATA_W-1:0] cols_raw,
                                  input logic [CSR_DATA_W-1:0] lines_raw);
      csr_we <= 1'b1;
      csr_idx <= CSR_COLS;
      csr_wdata <= cols_raw;
      @(negedge clock);
      csr_idx <= CSR_LINES;
      csr_wdata <= lines_raw;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_cmd(input int cols, input int lines, output bit counted);
      int sel, k;
      logic [FUNC_W-1:0] f;
      logic [CHAR_W-1:0] ch;
      logic [ARG_W-1:0]  c, r;
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 99);
      ch = CHAR_W'($urandom_range(0, 255));
      // mostly in the window, including one past each edge
      if ($urandom_range(0, 99) < 85) begin
         c = ARG_W'($urandom_range(0, cols));
         r = ARG_W'($urandom_range(0, lines));
      end else begin
         c = ARG_W'($urandom_range(0, 255));
         r = ARG_W'($urandom_range(0, 255));
      end
      counted = 1'b1;
      if (sel < 52) begin
         f = FUNC_PUT;
         if (k < 60) begin
            ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
         end else if (k < 72) begin
            ch = CH_LF;
         end else if (k < 86) begin
            ch = CHAR_W'($urandom_range(CH_BELL, CH_CR));
         end else begin
            counted = 1'b0;
            case ($urandom_range(0, 3))
               0: ch = CHAR_W'($urandom_range(0, CH_BELL - 1));
               1: ch = CHAR_W'($urandom_range(CH_CR + 1, CH_PRINT_LO - 1));
               2: ch = CHAR_W'(CH_PRINT_HI + 1);
               default: ch = CHAR_W'($urandom_range(128, 255));
            endcase
         end
      end else if (sel < 66) begin
         f = FUNC_GOTO;
      end else if (sel < 97) begin
         f = FUNC_READ;
      end else begin
         f = FUNC_CLEAR;
      end
      send_cmd(f, ch, c, r);
   endtask

   initial begin
      int sent, eff_cols, eff_lines;
      bit counted;
      logic [CSR_DATA_W-1:0] lines_raw;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: reset size 80x25
      send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd0);
      send_cmd(FUNC_READ, 8'h00, 8'd80, 8'd0);
      send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd25);
      send_cmd(FUNC_READ, 8'hFF, 8'd255, 8'd255);
      send_cmd(FUNC_PUT, CH_PRINT_LO, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, CH_PRINT_HI, 8'hFF, 8'hFF);
      send_cmd(FUNC_PUT, 8'h00, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, 8'h7F, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, 8'hFF, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, 8'h0E, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, CH_BELL, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, CH_BS, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, 8'h0B, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, 8'h0C, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, CH_CR, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, CH_BS, 8'd0, 8'd0);
      send_cmd(FUNC_GOTO, 8'h00, 8'd75, 8'd24);
      send_cmd(FUNC_PUT, CH_TAB, 8'd0, 8'd0);
      send_cmd(FUNC_PUT, 8'h41, 8'd0, 8'd0);   // wraps at the corner and scrolls
      send_cmd(FUNC_GOTO, 8'h00, 8'd80, 8'd3);
      send_cmd(FUNC_GOTO, 8'h00, 8'd3, 8'd25);
      send_cmd(FUNC_PUT, CH_LF, 8'd0, 8'd0);   // newline on the bottom row
      send_cmd(FUNC_READ, 8'h00, 8'd79, 8'd22);
      send_cmd(FUNC_CLEAR, 8'h00, 8'd0, 8'd0);
      send_cmd(FUNC_READ, 8'h00, 8'd0, 8'd0);

      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         idle_on <= (p < N_PHASES - 2);
         lines_raw = {2'($urandom_range(0, 3)), 5'(PHASE_LINES[p])};
         eff_cols = (PHASE_COLS[p] == 0) ? 1 : (PHASE_COLS[p] > 80 ? 80 : PHASE_COLS[p]);
         eff_lines = (PHASE_LINES[p] == 0) ? 1 : (PHASE_LINES[p] > 25 ? 25 : PHASE_LINES[p]);
         set_screen_size(7'(PHASE_COLS[p]), lines_raw);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_random_cmd(eff_cols, eff_lines, counted);
            sent += counted;
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_rsp == 0)
         $display("[text_terminal_char_buffer_top] OK");
      else
         $display("[text_terminal_char_buffer_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
